### hw/rtl/mlfq_pkg.sv
// Shared types and constants for the feedback-queue thread scheduler.
// No dependencies.
package mlfq_pkg;

    localparam int MAX_THREADS_DEF = 256;
    localparam int NUM_LEVELS_DEF  = 4;
    localparam int ID_W            = 8;
    localparam int ID_SPACE        = 256;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int OUT_LEVEL_W     = 2;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_QUANTUM = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_LOCK    = 3'd3,
        CMD_UNLOCK  = 3'd4,
        CMD_EXIT    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NO_RUN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LVL,
        S_PUSH,
        S_DR_RD,
        S_DR_ID,
        S_DR_LVL,
        S_DISP,
        S_DQ,
        S_FIN_RD,
        S_FIN
    } state_t;

endpackage

### hw/rtl/mlfq_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mlfq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/mlfq_thread_scheduler.sv
// Top level: multilevel feedback-queue thread scheduler with one mutex.
// Uses mlfq_pkg and mlfq_ram (ready queues, thread levels, blocked list).
//
// channel  | dir | fields (low bit up)
// s_axis   | in  | cmd[2:0], new_id[10:3]
// m_axis   | out | running_id[7:0], running_valid[8], running_level[10:9], status[12:11]
// cfg      | in  | policy_mlfq[0]
//
// One word at a time through a sequencer over three single-read RAMs.
// An unlock drains every blocked thread back into its ready queue before the result.
// Reset leaves the RAMs undefined; counts, heads and flags clear at once.
// A finished result sits in the output register; a new word is taken
// meanwhile, the next result waits for that register to free.
module mlfq_thread_scheduler #(
    parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mlfq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // cmd, new_id
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mlfq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // id, valid, level, status
    input  logic                               cfg_wen,
    input  logic                               cfg_wdata
);

    localparam int TW  = $clog2(MAX_THREADS);
    localparam int CW  = $clog2(MAX_THREADS + 1);
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int QD  = NUM_LEVELS * MAX_THREADS;
    localparam int QAW = $clog2(QD);
    localparam int IW  = mlfq_pkg::ID_W;
    localparam int LAW = $clog2(mlfq_pkg::ID_SPACE);

    mlfq_pkg::state_t state_reg, state_next;
    logic [mlfq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IW-1:0]                 id_reg, id_next;
    logic [LW-1:0]                 plv_reg, plv_next;
    logic                          drain_reg, drain_next;
    logic [mlfq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IW-1:0]                 cur_reg, cur_next;
    logic                          curv_reg, curv_next;
    logic                          held_reg, held_next;
    logic                          policy_reg;
    logic [TW-1:0]                 heads_reg [NUM_LEVELS];
    logic [TW-1:0]                 heads_next [NUM_LEVELS];
    logic [CW-1:0]                 counts_reg [NUM_LEVELS];
    logic [CW-1:0]                 counts_next [NUM_LEVELS];
    logic [CW-1:0]                 bcount_reg, bcount_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mlfq_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic           q_we;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [IW-1:0]  q_wdata, q_rdata;
    logic           l_we;
    logic [LAW-1:0] l_waddr, l_raddr;
    logic [LW-1:0]  l_wdata, l_rdata;
    logic           b_we;
    logic [TW-1:0]  b_waddr, b_raddr;
    logic [IW-1:0]  b_wdata, b_rdata;

    mlfq_ram #(.DEPTH(QD), .WIDTH(IW)) u_queues (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    mlfq_ram #(.DEPTH(mlfq_pkg::ID_SPACE), .WIDTH(LW)) u_levels (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    mlfq_ram #(.DEPTH(MAX_THREADS), .WIDTH(IW)) u_blocked (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    assign s_axis_tready = (state_reg == mlfq_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlfq_pkg::S_IDLE;
            cmd_reg       <= '0;
            id_reg        <= '0;
            plv_reg       <= '0;
            drain_reg     <= 1'b0;
            status_reg    <= '0;
            cur_reg       <= '0;
            curv_reg      <= 1'b0;
            held_reg      <= 1'b0;
            policy_reg    <= 1'b1;
            bcount_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                heads_reg[k]  <= '0;
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            plv_reg       <= plv_next;
            drain_reg     <= drain_next;
            status_reg    <= status_next;
            cur_reg       <= cur_next;
            curv_reg      <= curv_next;
            held_reg      <= held_next;
            bcount_reg    <= bcount_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_wen)
            begin
                policy_reg <= cfg_wdata;
            end
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                heads_reg[k]  <= heads_next[k];
                counts_reg[k] <= counts_next[k];
            end
        end
    end

    always_comb
    begin
        logic [LW-1:0]   lv;
        logic [CW:0]     sum;
        logic [TW-1:0]   slot;
        logic            found;
        logic [LW-1:0]   dlv;
        logic [CW-1:0]   inext;
        logic [mlfq_pkg::CMD_W-1:0] c;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        plv_next       = plv_reg;
        drain_next     = drain_reg;
        status_next    = status_reg;
        cur_next       = cur_reg;
        curv_next      = curv_reg;
        held_next      = held_reg;
        bcount_next    = bcount_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        heads_next     = heads_reg;
        counts_next    = counts_reg;
        q_we = 1'b0; q_waddr = '0; q_wdata = id_reg; q_raddr = '0;
        l_we = 1'b0; l_waddr = id_reg; l_wdata = plv_reg; l_raddr = cur_reg;
        b_we = 1'b0; b_waddr = bcount_reg[TW-1:0]; b_wdata = cur_reg;
        b_raddr = idx_reg[TW-1:0];
        lv = '0; sum = '0; slot = '0; found = 1'b0; dlv = '0;
        inext = idx_reg + CW'(1);
        c = s_axis_tdata[2:0];

        case (state_reg)
            mlfq_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = c;
                    status_next = mlfq_pkg::ST_OK;
                    drain_next  = 1'b0;
                    state_next  = mlfq_pkg::S_DISP;
                    if (!curv_reg && (c == mlfq_pkg::CMD_QUANTUM || c == mlfq_pkg::CMD_YIELD
                        || c == mlfq_pkg::CMD_LOCK || c == mlfq_pkg::CMD_EXIT))
                    begin
                        status_next = mlfq_pkg::ST_NO_RUN;
                    end
                    else
                    begin
                        case (c)
                            mlfq_pkg::CMD_CREATE:
                            begin
                                id_next    = s_axis_tdata[10:3];
                                plv_next   = '0;
                                state_next = mlfq_pkg::S_PUSH;
                            end
                            mlfq_pkg::CMD_QUANTUM, mlfq_pkg::CMD_YIELD:
                            begin
                                state_next = mlfq_pkg::S_LVL;
                            end
                            mlfq_pkg::CMD_LOCK:
                            begin
                                if (!held_reg)
                                begin
                                    held_next = 1'b1;
                                end
                                else
                                begin
                                    curv_next = 1'b0;
                                    if (bcount_reg < CW'(MAX_THREADS))
                                    begin
                                        b_we        = 1'b1;
                                        bcount_next = bcount_reg + CW'(1);
                                    end
                                    else
                                    begin
                                        status_next = mlfq_pkg::ST_FULL;
                                    end
                                end
                            end
                            mlfq_pkg::CMD_UNLOCK:
                            begin
                                held_next = 1'b0;
                                idx_next  = '0;
                                if (bcount_reg != '0)
                                begin
                                    state_next = mlfq_pkg::S_DR_RD;
                                end
                            end
                            mlfq_pkg::CMD_EXIT:
                            begin
                                curv_next = 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            mlfq_pkg::S_LVL:
            begin
                lv = policy_reg ? l_rdata : '0;
                if (cmd_reg == mlfq_pkg::CMD_QUANTUM && policy_reg
                    && lv != LW'(NUM_LEVELS - 1))
                begin
                    lv = lv + LW'(1);
                end
                curv_next  = 1'b0;
                plv_next   = lv;
                id_next    = cur_reg;
                state_next = mlfq_pkg::S_PUSH;
            end
            mlfq_pkg::S_PUSH:
            begin
                if (counts_reg[plv_reg] >= CW'(MAX_THREADS))
                begin
                    status_next = mlfq_pkg::ST_FULL;
                end
                else
                begin
                    sum = (CW+1)'(heads_reg[plv_reg]) + (CW+1)'(counts_reg[plv_reg]);
                    if (sum >= (CW+1)'(MAX_THREADS))
                    begin
                        sum = sum - (CW+1)'(MAX_THREADS);
                    end
                    slot    = sum[TW-1:0];
                    q_we    = 1'b1;
                    q_waddr = QAW'(QAW'(plv_reg) * QAW'(MAX_THREADS) + QAW'(slot));
                    l_we    = 1'b1;
                    counts_next[plv_reg] = counts_reg[plv_reg] + CW'(1);
                end
                state_next = mlfq_pkg::S_DISP;
                if (drain_reg)
                begin
                    idx_next = inext;
                    if (inext < bcount_reg)
                    begin
                        state_next = mlfq_pkg::S_DR_RD;
                    end
                    else
                    begin
                        bcount_next = '0;
                    end
                end
            end
            mlfq_pkg::S_DR_RD:
            begin
                state_next = mlfq_pkg::S_DR_ID;
            end
            mlfq_pkg::S_DR_ID:
            begin
                id_next    = b_rdata;
                l_raddr    = b_rdata;
                state_next = mlfq_pkg::S_DR_LVL;
            end
            mlfq_pkg::S_DR_LVL:
            begin
                plv_next   = policy_reg ? l_rdata : '0;
                drain_next = 1'b1;
                state_next = mlfq_pkg::S_PUSH;
            end
            mlfq_pkg::S_DISP:
            begin
                state_next = mlfq_pkg::S_FIN_RD;
                if (!curv_reg)
                begin
                    for (int k = 0; k < NUM_LEVELS; k++)
                    begin
                        if (!found && (policy_reg || k == 0) && counts_reg[k] != '0)
                        begin
                            found = 1'b1;
                            dlv   = LW'(k);
                        end
                    end
                    if (found)
                    begin
                        q_raddr = QAW'(QAW'(dlv) * QAW'(MAX_THREADS) + QAW'(heads_reg[dlv]));
                        heads_next[dlv]  = (heads_reg[dlv] == TW'(MAX_THREADS - 1))
                                         ? '0 : heads_reg[dlv] + TW'(1);
                        counts_next[dlv] = counts_reg[dlv] - CW'(1);
                        curv_next  = 1'b1;
                        state_next = mlfq_pkg::S_DQ;
                    end
                end
            end
            mlfq_pkg::S_DQ:
            begin
                cur_next   = q_rdata;
                state_next = mlfq_pkg::S_FIN_RD;
            end
            mlfq_pkg::S_FIN_RD:
            begin
                state_next = mlfq_pkg::S_FIN;
            end
            mlfq_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[7:0]   = curv_reg ? cur_reg : '0;
                    out_data_next[8]     = curv_reg;
                    out_data_next[10:9]  = curv_reg ? mlfq_pkg::OUT_LEVEL_W'(l_rdata) : '0;
                    out_data_next[12:11] = status_reg;
                    state_next = mlfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mlfq_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted word did not start work");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0
            && m_axis_tdata[10:9] == 2'd0))
        else $error("idle result carries id or level");

    a_bcount: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= CW'(MAX_THREADS))
        else $error("blocked count overflow");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlfq_pkg::S_FIN) |-> (bcount_reg == '0 || cmd_reg != mlfq_pkg::CMD_UNLOCK
            || status_reg == mlfq_pkg::ST_NO_RUN))
        else $error("unlock left blocked threads");

endmodule
